// ===== design/port_demux_frame_receiver_assert.svh =====
// Assertion macros shared by the receiver's modules.
// Each expects signals named clk and rst in the module that uses it.
`ifndef PORT_DEMUX_FRAME_RECEIVER_ASSERT_SVH
`define PORT_DEMUX_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PDFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PDFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pdfr_pkg.sv =====
// Package for the port demux frame receiver: sizes, codes, state types and
// the command/status structs between controller and datapath. No dependencies.
package pdfr_pkg;

  localparam int PORT_COUNT = 256;
  localparam int IDX_W      = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int CHUNK_W    = 16;
  localparam int CHUNKS     = (PORT_COUNT + CHUNK_W - 1) / CHUNK_W;
  localparam int CH_W       = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam logic [7:0] SYNC_BYTE = 8'h5A;
  localparam logic [8:0] NO_LIMIT  = 9'd256;

  typedef enum logic [1:0] {
    MODE_BYTE    = 2'd0,
    MODE_REG     = 2'd1,
    MODE_ALLOC   = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    KIND_REGISTERED = 4'd0,
    KIND_OCCUPIED   = 4'd1,
    KIND_ALLOCATED  = 4'd2,
    KIND_NO_FREE    = 4'd3,
    KIND_RELEASED   = 4'd4,
    KIND_IDLE       = 4'd5,
    KIND_PAYLOAD    = 4'd6,
    KIND_EMPTY      = 4'd7,
    KIND_CAP_ERROR  = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_PORT = 2'd1,
    PH_LEN  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DECODE = 2'd1,
    ST_LOOKUP = 2'd2,
    ST_SCAN   = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] byte_value;
    logic [7:0] port;
    logic       once_only;
    logic       limit_enabled;
    logic [7:0] capacity;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] port_out;
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       once_only;
    logic       limit_enabled;
    logic [7:0] capacity;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic mem_rd;
    logic scan_start;
    logic scan_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_lookup;
    logic need_scan;
    logic scan_hit;
    logic scan_last;
    logic has_result;
    logic out_free;
  } dp_status_t;

  function automatic logic port_in_range(input logic [7:0] p);
    return {1'b0, p} < 9'(PORT_COUNT);
  endfunction

endpackage

// ===== design/pdfr_stream_if.sv =====
// Valid/ready channel interfaces for the receiver's input items and results.
// Plain widths only; no package dependency.
interface pdfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] byte_value;
  logic [7:0] port;
  logic       once_only;
  logic       limit_enabled;
  logic [7:0] capacity;

  modport source(output valid, mode, byte_value, port, once_only, limit_enabled, capacity,
                 input ready);
  modport sink(input valid, mode, byte_value, port, once_only, limit_enabled, capacity,
               output ready);
endinterface

interface pdfr_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] port_out;
  logic [7:0] data;
  logic       last;

  modport source(output valid, kind, port_out, data, last, input ready);
  modport sink(input valid, kind, port_out, data, last, output ready);
endinterface

// ===== design/pdfr_ctrl.sv =====
// Controller state machine: sequences accept, table lookup, free-port scan
// and commit. Uses pdfr_pkg and the assertion macro header.
`include "port_demux_frame_receiver_assert.svh"

module pdfr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pdfr_pkg::dp_status_t   stat,
  output pdfr_pkg::ctrl_cmd_t    cmd
);
  import pdfr_pkg::*;

  ctrl_state_t state, state_next;
  logic        can_commit;

  assign can_commit = !stat.has_result || stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.need_lookup) begin
          cmd.mem_rd = 1'b1;
          state_next = ST_LOOKUP;
        end else if (stat.need_scan) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end else if (can_commit) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        if (can_commit) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (stat.scan_hit || stat.scan_last) begin
          if (can_commit) begin
            cmd.commit = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `PDFR_ASSERT_NOW(a_commit_room, cmd.commit && stat.has_result, stat.out_free,
                   "commit with a result while the output register is full")
  `PDFR_ASSERT_NOW(a_lookup_after_read, state == ST_LOOKUP, $past(cmd.mem_rd),
                   "lookup state entered without a table read")

endmodule

// ===== design/pdfr_datapath.sv =====
// Datapath: item register, frame parser state, listener valid flags, entry
// memory, free-port scan and output register. Uses pdfr_pkg and the macros.
`include "port_demux_frame_receiver_assert.svh"

module pdfr_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  pdfr_pkg::item_t       in_item,
  input  pdfr_pkg::ctrl_cmd_t   cmd,
  output pdfr_pkg::dp_status_t  stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output pdfr_pkg::result_t     out_res
);
  import pdfr_pkg::*;

  item_t                     item;
  phase_t                    phase, phase_next;
  logic [7:0]                frame_port, frame_port_next;
  logic [7:0]                bytes_left, bytes_left_next;
  logic                      discarding, discarding_next;
  logic [8:0]                frame_limit, frame_limit_next;
  logic [PORT_COUNT-1:0]     valid;
  entry_t                    mem [PORT_COUNT];
  entry_t                    rdata;
  logic [CH_W-1:0]           scan_chunk;

  logic [IDX_W-1:0]          port_idx, byte_idx, free_idx;
  logic [IDX_W-1:0]          set_idx, clr_idx, wr_idx;
  logic                      set_en, clr_en, wr_en;
  logic                      port_busy, byte_busy;
  logic [CHUNKS*CHUNK_W-1:0] padded;
  logic [CHUNK_W-1:0]        chunk;
  logic [3:0]                free_pos;
  logic                      scan_hit;
  logic [7:0]                free_port;
  logic                      is_last;
  logic                      has_res;
  result_t                   res;

  assign port_idx  = item.port[IDX_W-1:0];
  assign byte_idx  = item.byte_value[IDX_W-1:0];
  assign port_busy = port_in_range(item.port) && valid[port_idx];
  assign byte_busy = port_in_range(item.byte_value) && valid[byte_idx];

  // Padding flags past the last port read as taken, so the scan never hits them.
  always_comb begin
    padded                 = '1;
    padded[PORT_COUNT-1:0] = valid;
  end

  assign chunk = padded[{scan_chunk, 4'b0000} +: CHUNK_W];

  always_comb begin
    scan_hit = 1'b0;
    free_pos = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (!chunk[i]) begin
        scan_hit = 1'b1;
        free_pos = 4'(i);
      end
    end
  end

  assign free_port = 8'({scan_chunk, free_pos});
  assign free_idx  = free_port[IDX_W-1:0];
  assign is_last   = bytes_left <= 8'd1;

  always_comb begin
    has_res          = 1'b0;
    res.kind         = KIND_REGISTERED;
    res.port_out     = item.port;
    res.data         = '0;
    res.last         = 1'b0;
    phase_next       = phase;
    frame_port_next  = frame_port;
    bytes_left_next  = bytes_left;
    discarding_next  = discarding;
    frame_limit_next = frame_limit;
    set_en           = 1'b0;
    set_idx          = port_idx;
    clr_en           = 1'b0;
    clr_idx          = port_idx;
    wr_en            = 1'b0;
    wr_idx           = port_idx;
    case (item.mode)
      MODE_BYTE: begin
        case (phase)
          PH_HUNT: begin
            if (item.byte_value == SYNC_BYTE) begin
              phase_next = PH_PORT;
            end
          end
          PH_PORT: begin
            frame_port_next = item.byte_value;
            phase_next      = PH_LEN;
            if (byte_busy) begin
              discarding_next  = 1'b0;
              frame_limit_next = rdata.limit_enabled ? {1'b0, rdata.capacity} : NO_LIMIT;
              if (rdata.once_only) begin
                clr_en  = 1'b1;
                clr_idx = byte_idx;
              end
            end else begin
              discarding_next  = 1'b1;
              frame_limit_next = NO_LIMIT;
            end
          end
          PH_LEN: begin
            res.port_out = frame_port;
            if (discarding) begin
              bytes_left_next = item.byte_value;
              phase_next      = (item.byte_value == 8'd0) ? PH_HUNT : PH_DATA;
            end else if ({1'b0, item.byte_value} > frame_limit) begin
              phase_next = PH_HUNT;
              has_res    = 1'b1;
              res.kind   = KIND_CAP_ERROR;
            end else if (item.byte_value == 8'd0) begin
              phase_next = PH_HUNT;
              has_res    = 1'b1;
              res.kind   = KIND_EMPTY;
              res.last   = 1'b1;
            end else begin
              bytes_left_next = item.byte_value;
              phase_next      = PH_DATA;
            end
          end
          PH_DATA: begin
            bytes_left_next = is_last ? 8'd0 : bytes_left - 8'd1;
            if (is_last) begin
              phase_next = PH_HUNT;
            end
            has_res      = !discarding;
            res.kind     = KIND_PAYLOAD;
            res.port_out = frame_port;
            res.data     = item.byte_value;
            res.last     = is_last;
          end
          default: begin
            phase_next = PH_HUNT;
          end
        endcase
      end
      MODE_REG: begin
        has_res = 1'b1;
        if (!port_in_range(item.port) || port_busy) begin
          res.kind = KIND_OCCUPIED;
        end else begin
          res.kind = KIND_REGISTERED;
          wr_en    = 1'b1;
          set_en   = 1'b1;
        end
      end
      MODE_ALLOC: begin
        has_res = 1'b1;
        if (scan_hit) begin
          res.kind     = KIND_ALLOCATED;
          res.port_out = free_port;
          wr_en        = 1'b1;
          wr_idx       = free_idx;
          set_en       = 1'b1;
          set_idx      = free_idx;
        end else begin
          res.kind     = KIND_NO_FREE;
          res.port_out = '0;
        end
      end
      MODE_RELEASE: begin
        has_res = 1'b1;
        if (port_busy) begin
          res.kind = KIND_RELEASED;
          clr_en   = 1'b1;
        end else begin
          res.kind = KIND_IDLE;
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  always_comb begin
    stat.need_lookup = (item.mode == MODE_BYTE) && (phase == PH_PORT);
    stat.need_scan   = (item.mode == MODE_ALLOC);
    stat.scan_hit    = scan_hit;
    stat.scan_last   = scan_chunk == CH_W'(CHUNKS - 1);
    stat.has_result  = has_res;
    stat.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rdata <= mem[byte_idx];
    end
    if (cmd.commit && wr_en) begin
      mem[wr_idx] <= '{once_only: item.once_only, limit_enabled: item.limit_enabled,
                       capacity: item.capacity};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      frame_port  <= '0;
      bytes_left  <= '0;
      discarding  <= 1'b0;
      frame_limit <= '0;
      valid       <= '0;
      scan_chunk  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_chunk <= '0;
      end else if (cmd.scan_step) begin
        scan_chunk <= scan_chunk + 1'b1;
      end
      if (cmd.commit) begin
        phase       <= phase_next;
        frame_port  <= frame_port_next;
        bytes_left  <= bytes_left_next;
        discarding  <= discarding_next;
        frame_limit <= frame_limit_next;
        if (set_en) begin
          valid[set_idx] <= 1'b1;
        end
        if (clr_en) begin
          valid[clr_idx] <= 1'b0;
        end
      end
      if (cmd.commit && has_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && has_res) begin
      out_res <= res;
    end
  end

  `PDFR_ASSERT_NOW(a_data_count, phase == PH_DATA, bytes_left != 8'd0,
                   "payload phase with no bytes left")
  `PDFR_ASSERT_NOW(a_scan_bound, cmd.scan_step, !stat.scan_last,
                   "free-port scan advanced past the last chunk")
  `PDFR_ASSERT_NEXT(a_result_loaded, cmd.commit && has_res, out_valid,
                    "committed result not presented")

endmodule

// ===== design/port_demux_frame_receiver.sv =====
// Top level of the port demux frame receiver: controller plus datapath.
// Depends on pdfr_pkg, pdfr_stream_if, pdfr_ctrl and pdfr_datapath.
//
// One item is in flight at a time. A stream byte, register and release
// are decoded and committed; the port byte of a frame also passes a lookup
// state (the listener entry comes from a memory with a registered read),
// and register at the lowest free port runs the free-port scan, which
// covers 16 listener flags per cycle. A result waits in an output
// register; an item that yields a result holds there while that register is
// still full. Listener flags are flip-flops cleared by reset, so the block is
// ready right after reset with no clearing pass.
module port_demux_frame_receiver (
  input logic       clk,
  input logic       rst,
  pdfr_in_if.sink   in_ch,
  pdfr_out_if.source out_ch
);
  import pdfr_pkg::*;

  item_t      in_item;
  ctrl_cmd_t  cmd;
  dp_status_t stat;
  result_t    out_res;
  logic       ready;
  logic       out_valid;

  assign in_item.mode          = mode_t'(in_ch.mode);
  assign in_item.byte_value    = in_ch.byte_value;
  assign in_item.port          = in_ch.port;
  assign in_item.once_only     = in_ch.once_only;
  assign in_item.limit_enabled = in_ch.limit_enabled;
  assign in_item.capacity      = in_ch.capacity;
  assign in_ch.ready           = ready;

  pdfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pdfr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_ch.valid    = out_valid;
  assign out_ch.kind     = out_res.kind;
  assign out_ch.port_out = out_res.port_out;
  assign out_ch.data     = out_res.data;
  assign out_ch.last     = out_res.last;

endmodule
